>>> rtl/core/fmg_pkg.sv
`timescale 1ns / 1ps
package fmg_pkg;

  localparam int MAX_DIM         = 1024;
  localparam int VALUE_FRAC_BITS = 16;
  localparam int COORD_W         = 10;
  localparam int SIZE_W          = 11;
  localparam int CUT_W           = 16;
  localparam int GAIN_W          = VALUE_FRAC_BITS + 1;
  localparam int D2_W            = 2 * COORD_W + 1;
  localparam int C2_W            = 2 * CUT_W;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  // Gaussian lane structure
  localparam int DIV_STEPS    = 22;
  localparam int SERIES_TERMS = 13;
  localparam int POW_STEPS    = 31;
  localparam int LANE_DEPTH   = DIV_STEPS + 3 * SERIES_TERMS + POW_STEPS + 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {VALUE_FRAC_BITS{1'b0}}};

  // exp(-1) in Q32 as the truncated alternating series of 1/k! gives it
  localparam longint unsigned Q32_ONE = 64'd1 << 32;
  localparam longint unsigned EXP_M1_FULL =
      Q32_ONE - Q32_ONE + Q32_ONE / 64'd2 - Q32_ONE / 64'd6 + Q32_ONE / 64'd24
      - Q32_ONE / 64'd120 + Q32_ONE / 64'd720 - Q32_ONE / 64'd5040
      + Q32_ONE / 64'd40320 - Q32_ONE / 64'd362880 + Q32_ONE / 64'd3628800
      - Q32_ONE / 64'd39916800 + Q32_ONE / 64'd479001600
      - Q32_ONE / 64'd6227020800;
  localparam logic [31:0] EXP_M1_Q32 = EXP_M1_FULL[31:0];

  typedef enum logic [2:0] {
    KIND_IDEAL_LOW  = 3'd0,
    KIND_GAUSS_LOW  = 3'd1,
    KIND_IDEAL_HIGH = 3'd2,
    KIND_GAUSS_HIGH = 3'd3,
    KIND_IDEAL_BAND = 3'd4,
    KIND_GAUSS_BAND = 3'd5,
    KIND_ZERO_A     = 3'd6,
    KIND_ZERO_B     = 3'd7
  } filter_kind_t;

  typedef enum logic [2:0] {
    REG_KIND   = 3'd0,
    REG_CUT_LO = 3'd1,
    REG_CUT_HI = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] mask_value;
    logic              config_error;
  } out_item_t;

  typedef struct packed {
    filter_kind_t       kind;
    logic [CUT_W-1:0]   cut_lo;
    logic [CUT_W-1:0]   cut_hi;
    logic [C2_W-1:0]    lo2;
    logic [C2_W-1:0]    hi2;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
  } cfg_t;

  typedef struct packed {
    filter_kind_t    kind;
    logic            hit;
    logic            err;
    logic [D2_W-1:0] d2;
  } req_t;

  typedef struct packed {
    filter_kind_t kind;
    logic         hit;
    logic         err;
  } meta_t;

endpackage

>>> rtl/core/fmg_cfg_regs.sv
`timescale 1ns / 1ps
module fmg_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [fmg_pkg::ADDR_W-1:0] paddr,
  input  logic [fmg_pkg::DATA_W-1:0] pwdata,
  output logic [fmg_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output fmg_pkg::cfg_t             cfg
);
  import fmg_pkg::*;

  filter_kind_t      kind_r;
  logic [CUT_W-1:0]  cut_lo_r;
  logic [CUT_W-1:0]  cut_hi_r;
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  reg_idx_t          idx;
  logic              wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_IDEAL_LOW;
      cut_lo_r <= '0;
      cut_hi_r <= '0;
      width_r  <= SIZE_W'(MAX_DIM);
      height_r <= SIZE_W'(MAX_DIM);
    end else if (wr) begin
      unique case (idx)
        REG_KIND:   kind_r   <= filter_kind_t'(pwdata[2:0]);
        REG_CUT_LO: cut_lo_r <= pwdata[CUT_W-1:0];
        REG_CUT_HI: cut_hi_r <= pwdata[CUT_W-1:0];
        REG_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_KIND:   prdata = DATA_W'(kind_r);
      REG_CUT_LO: prdata = DATA_W'(cut_lo_r);
      REG_CUT_HI: prdata = DATA_W'(cut_hi_r);
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  // oversized images are clamped to the largest supported size
  always_comb begin
    cfg.kind   = kind_r;
    cfg.cut_lo = cut_lo_r;
    cfg.cut_hi = cut_hi_r;
    cfg.lo2    = cut_lo_r * cut_lo_r;
    cfg.hi2    = cut_hi_r * cut_hi_r;
    cfg.cx     = (width_r > SIZE_W'(MAX_DIM)) ? COORD_W'(MAX_DIM / 2)
                                               : width_r[SIZE_W-1:1];
    cfg.cy     = (height_r > SIZE_W'(MAX_DIM)) ? COORD_W'(MAX_DIM / 2)
                                                : height_r[SIZE_W-1:1];
  end

endmodule

>>> rtl/core/fmg_front.sv
`timescale 1ns / 1ps
module fmg_front (
  input  logic              in_valid,
  input  fmg_pkg::in_item_t in_data,
  input  fmg_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output fmg_pkg::req_t     req
);
  import fmg_pkg::*;

  logic signed [COORD_W+1:0]   dx;
  logic signed [COORD_W+1:0]   dy;
  logic signed [2*COORD_W+3:0] sqx;
  logic signed [2*COORD_W+3:0] sqy;
  logic [D2_W-1:0]             d2;
  logic [C2_W-1:0]             d2s;
  logic                        bad_band;

  assign dx  = signed'({2'b00, in_data.column}) - signed'({2'b00, cfg.cx});
  assign dy  = signed'({2'b00, in_data.row}) - signed'({2'b00, cfg.cy});
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  // each square is below 2^20
  assign d2  = {1'b0, sqx[2*COORD_W-1:0]} + {1'b0, sqy[2*COORD_W-1:0]};
  assign d2s = C2_W'({d2, 8'h00});
  assign bad_band = cfg.cut_lo >= cfg.cut_hi;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    req.kind = cfg.kind;
    req.d2   = d2;
    req.hit  = 1'b0;
    req.err  = 1'b0;
    case (cfg.kind)
      KIND_IDEAL_LOW:  req.hit = d2s <= cfg.lo2;
      KIND_IDEAL_HIGH: req.hit = d2s >= cfg.lo2;
      KIND_IDEAL_BAND: begin
        req.hit = (d2s >= cfg.lo2) && (d2s <= cfg.hi2);
        req.err = bad_band;
      end
      KIND_GAUSS_BAND: req.err = bad_band;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/fmg_queue.sv
`timescale 1ns / 1ps
module fmg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fmg_pkg::req_t wdata,
  input  logic          pop,
  output logic          rvalid,
  output fmg_pkg::req_t rdata,
  output logic          full
);
  import fmg_pkg::*;

  req_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_pop;

  assign rvalid = cnt_r != 2'd0;
  assign full   = cnt_r == 2'd2;
  assign rdata  = mem_r[rd_ptr_r];
  assign do_pop = pop && rvalid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(do_pop);
    end
  end

endmodule

>>> rtl/core/fmg_gauss_lane.sv
`timescale 1ns / 1ps
module fmg_gauss_lane (
  input  logic                      clk,
  input  logic                      en,
  input  logic [fmg_pkg::D2_W-1:0]  d2,
  input  logic [fmg_pkg::C2_W-1:0]  c2,
  output logic [fmg_pkg::GAIN_W-1:0] gain
);
  import fmg_pkg::*;

  localparam int RND_SH = 32 - VALUE_FRAC_BITS;

  typedef struct packed {
    logic zero;
    logic one;
  } spec_t;

  typedef struct packed {
    logic [32:0]        val;
    logic signed [35:0] sum;
    logic [15:0]        f;
    logic [4:0]         n;
    spec_t              sp;
  } ser_t;

  // ---- restoring divider: x = (d2 << 23) / c2, only when x < 2^21 ----
  logic [C2_W-1:0]      dv_rem_r  [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_q_r    [DIV_STEPS];
  spec_t                dv_spec_r [DIV_STEPS];
  spec_t                sp_in;

  always_comb begin
    if (c2 == '0) begin
      sp_in.one  = d2 == '0;
      sp_in.zero = d2 != '0;
    end else begin
      sp_in.one  = 1'b0;
      sp_in.zero = C2_W'({d2, 2'b00}) >= c2;  // exponent integer part >= 32
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [C2_W-1:0]      rem_p;
    logic [DIV_STEPS-1:0] q_p;
    spec_t                sp_p;
    logic [C2_W:0]        sh;
    logic                 ge;
    if (j == 0) begin : g_first
      assign rem_p = C2_W'({d2, 1'b0});
      assign q_p   = '0;
      assign sp_p  = sp_in;
    end else begin : g_next
      assign rem_p = dv_rem_r[j-1];
      assign q_p   = dv_q_r[j-1];
      assign sp_p  = dv_spec_r[j-1];
    end
    assign sh = {rem_p, 1'b0};
    assign ge = sh >= {1'b0, c2};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j]  <= ge ? C2_W'(sh - {1'b0, c2}) : C2_W'(sh);
        dv_q_r[j]    <= q_p | (DIV_STEPS'(ge) << (DIV_STEPS - 1 - j));
        dv_spec_r[j] <= sp_p;
      end
    end
  end

  // ---- series for exp(-f), three stages per term ----
  ser_t        sa_r [SERIES_TERMS];
  ser_t        sb_r [SERIES_TERMS];
  logic [32:0] sq_r [SERIES_TERMS];
  ser_t        sc_r [SERIES_TERMS];

  for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_ser
    localparam int K = i + 1;
    ser_t        prev;
    logic [48:0] prod_a;
    logic [32:0] q_fix;
    ser_t        c_nxt;
    ser_t        a_nxt;
    if (i == 0) begin : g_first
      always_comb begin
        prev.val = 33'(Q32_ONE);
        prev.sum = 36'(Q32_ONE);
        prev.f   = dv_q_r[DIV_STEPS-1][15:0];
        prev.n   = dv_q_r[DIV_STEPS-1][20:16];
        prev.sp  = dv_spec_r[DIV_STEPS-1];
      end
    end else begin : g_next
      assign prev = sc_r[i-1];
    end
    assign prod_a = prev.val * prev.f;

    always_comb begin
      a_nxt     = prev;
      a_nxt.val = prod_a[48:16];
    end

    if (K == 1) begin : g_nodiv
      assign q_fix = sb_r[i].val;
      always_ff @(posedge clk) begin
        if (en) begin
          sq_r[i] <= sa_r[i].val;
        end
      end
    end else begin : g_div
      localparam logic [35:0] RCP = 36'((64'd1 << 36) / K);
      logic [68:0] prod_b;
      logic [36:0] qk;
      logic [36:0] rem;
      assign prod_b = sa_r[i].val * RCP;
      assign qk     = sq_r[i] * 37'(K);
      assign rem    = {4'h0, sb_r[i].val} - qk;
      // reciprocal estimate is low by at most one
      assign q_fix  = (rem >= 37'(K)) ? sq_r[i] + 33'd1 : sq_r[i];
      always_ff @(posedge clk) begin
        if (en) begin
          sq_r[i] <= prod_b[68:36];
        end
      end
    end

    always_comb begin
      c_nxt     = sb_r[i];
      c_nxt.val = q_fix;
      if (K % 2 == 1) begin
        c_nxt.sum = sb_r[i].sum - signed'({3'b000, q_fix});
      end else begin
        c_nxt.sum = sb_r[i].sum + signed'({3'b000, q_fix});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sa_r[i] <= a_nxt;
        sb_r[i] <= sa_r[i];
        sc_r[i] <= c_nxt;
      end
    end
  end

  // ---- n repeated multiplications by exp(-1) ----
  logic [32:0] pw_acc_r [POW_STEPS];
  logic [4:0]  pw_n_r   [POW_STEPS];
  spec_t       pw_sp_r  [POW_STEPS];
  logic [32:0] acc_in;

  always_comb begin
    if (sc_r[SERIES_TERMS-1].sum < 0) begin
      acc_in = '0;
    end else if (sc_r[SERIES_TERMS-1].sum > 36'(Q32_ONE)) begin
      acc_in = 33'(Q32_ONE);
    end else begin
      acc_in = sc_r[SERIES_TERMS-1].sum[32:0];
    end
  end

  for (genvar i = 0; i < POW_STEPS; i++) begin : g_pow
    logic [32:0] acc_p;
    logic [4:0]  n_p;
    spec_t       sp_p;
    logic [64:0] prod;
    if (i == 0) begin : g_first
      assign acc_p = acc_in;
      assign n_p   = sc_r[SERIES_TERMS-1].n;
      assign sp_p  = sc_r[SERIES_TERMS-1].sp;
    end else begin : g_next
      assign acc_p = pw_acc_r[i-1];
      assign n_p   = pw_n_r[i-1];
      assign sp_p  = pw_sp_r[i-1];
    end
    assign prod = acc_p * EXP_M1_Q32 + 65'(64'd1 << 31);
    always_ff @(posedge clk) begin
      if (en) begin
        pw_acc_r[i] <= (n_p > 5'(i)) ? prod[64:32] : acc_p;
        pw_n_r[i]   <= n_p;
        pw_sp_r[i]  <= sp_p;
      end
    end
  end

  // ---- rounding to the gain format ----
  logic [GAIN_W-1:0] gain_r;
  logic [33:0]       rnd;

  assign rnd  = {1'b0, pw_acc_r[POW_STEPS-1]} + 34'(64'd1 << (RND_SH - 1));
  assign gain = gain_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (pw_sp_r[POW_STEPS-1].one) begin
        gain_r <= GAIN_ONE;
      end else if (pw_sp_r[POW_STEPS-1].zero) begin
        gain_r <= '0;
      end else begin
        gain_r <= rnd[RND_SH+GAIN_W-1:RND_SH];
      end
    end
  end

endmodule

>>> rtl/core/fmg_back.sv
`timescale 1ns / 1ps
module fmg_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fmg_pkg::cfg_t            cfg,
  input  logic                     q_valid,
  input  fmg_pkg::req_t            q_data,
  output logic                     pop,
  output logic                     out_valid,
  output fmg_pkg::out_item_t       out_data,
  input  logic                     out_stall
);
  import fmg_pkg::*;

  logic              en;
  logic              mv_r [LANE_DEPTH];
  meta_t             md_r [LANE_DEPTH];
  logic              out_valid_r;
  out_item_t         out_r;
  out_item_t         out_nxt;
  logic [GAIN_W-1:0] g_lo;
  logic [GAIN_W-1:0] g_hi;
  meta_t             m_end;

  // whole back end advances together; bubbles ride along
  assign en  = !out_valid_r || !out_stall;
  assign pop = en && q_valid;

  fmg_gauss_lane u_lane_lo (
    .clk  (clk),
    .en   (en),
    .d2   (q_data.d2),
    .c2   (cfg.lo2),
    .gain (g_lo)
  );

  fmg_gauss_lane u_lane_hi (
    .clk  (clk),
    .en   (en),
    .d2   (q_data.d2),
    .c2   (cfg.hi2),
    .gain (g_hi)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      md_r[0].kind <= q_data.kind;
      md_r[0].hit  <= q_data.hit;
      md_r[0].err  <= q_data.err;
      for (int i = 1; i < LANE_DEPTH; i++) begin
        md_r[i] <= md_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_DEPTH; i++) begin
        mv_r[i] <= 1'b0;
      end
    end else if (en) begin
      mv_r[0] <= q_valid;
      for (int i = 1; i < LANE_DEPTH; i++) begin
        mv_r[i] <= mv_r[i-1];
      end
    end
  end

  assign m_end = md_r[LANE_DEPTH-1];

  always_comb begin
    out_nxt.mask_value   = '0;
    out_nxt.config_error = m_end.err;
    if (!m_end.err) begin
      case (m_end.kind)
        KIND_IDEAL_LOW, KIND_IDEAL_HIGH, KIND_IDEAL_BAND:
          out_nxt.mask_value = m_end.hit ? GAIN_ONE : '0;
        KIND_GAUSS_LOW:  out_nxt.mask_value = g_lo;
        KIND_GAUSS_HIGH: out_nxt.mask_value = GAIN_ONE - g_lo;
        KIND_GAUSS_BAND: out_nxt.mask_value = (g_hi > g_lo) ? g_hi - g_lo : '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mv_r[LANE_DEPTH-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/frequency_mask_generator.sv
`timescale 1ns / 1ps
// Frequency-domain filter mask generator.
// Input channel (in_valid/in_stall/in_data) takes one pixel coordinate per
// request; the output channel (out_valid/out_stall/out_data) returns its gain
// as Q16 (65536 = 1.0) plus a flag for a bandpass with bad cutoffs.
// An APB port (psel..pready) holds kind, cutoffs and image size; change them
// only while no request is in flight.
// Throughput: one request per cycle while out_stall is low.
// Path: an accepted request passes the 2-entry request queue, 93 stages of
// Gaussian lane (22 divider steps, 13 series terms at 3 stages each, 31
// exp(-1) multiply steps, one rounding stage) and the output register, then
// out_valid rises. Ideal kinds ride through the same pipeline.
// When out_stall is high while out_valid is high the whole back end holds;
// the queue then fills and in_stall rises once both queue entries are taken.
// Reset (rst_n low, synchronous) empties queue and pipeline and loads kind 0,
// cutoffs 0 and a 1024 x 1024 image.
module frequency_mask_generator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fmg_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fmg_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fmg_pkg::ADDR_W-1:0] paddr,
  input  logic [fmg_pkg::DATA_W-1:0] pwdata,
  output logic [fmg_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import fmg_pkg::*;

  cfg_t cfg;
  req_t req;
  req_t q_data;
  logic push;
  logic pop;
  logic q_valid;
  logic q_full;

  fmg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fmg_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .req      (req)
  );

  fmg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (req),
    .pop    (pop),
    .rvalid (q_valid),
    .rdata  (q_data),
    .full   (q_full)
  );

  fmg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule
